/* src/msrf_pkg.sv */
// Shared types and constants for the min/max stretch and rotate frame block.
// No dependencies; every other file in src but msrf_ram imports this package.
`default_nettype none

package msrf_pkg;

    localparam int FRAME_COLS = 256;
    localparam int FRAME_ROWS = 192;
    localparam int PIXELS     = FRAME_COLS * FRAME_ROWS;

    localparam int PIX_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int GRAY_W  = 8;
    localparam int ADDR_W  = $clog2(PIXELS);
    localparam int COUNT_W = $clog2(PIXELS + 1);
    localparam int COL_W   = $clog2(FRAME_COLS);
    localparam int ROW_W   = $clog2(FRAME_ROWS + 1);

    // Restoring divider: one quotient bit per step, quotient fits in GRAY_W bits.
    localparam int NUM_W     = PIX_W + GRAY_W;
    localparam int DIV_STEPS = GRAY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};
    localparam logic [PIX_W-1:0]  PIX_MAX  = {PIX_W{1'b1}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] raw_byte;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              last_pixel;
        logic              flat_frame;
        logic [PIX_W-1:0]  frame_min;
        logic [PIX_W-1:0]  frame_max;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take a raw byte word
        logic read;      // start readout: issue RAM read, advance index
        logic prep;      // classify fetched pixel, set up divider
        logic div_step;  // one restoring division step
        logic out_load;  // move result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register full and not being taken
    } stat_t;

endpackage

`default_nettype wire

/* src/minmax_stretch_rotate_frame.sv */
// Min/max contrast stretch with 90-degree clockwise rotation. Load words (func 0) take one raw
// byte per cycle while no readout is in progress; byte pairs form little-endian 16-bit pixels
// that are written to a 256x192 frame RAM at their rotated position while the frame minimum and
// maximum are tracked. Readout words (func 1) return the rotated frame in order, one 8-bit
// stretched gray value each. A readout occupies the block through one RAM read, a step to
// classify the pixel and set up the divide, eight restoring division steps (one quotient bit
// each) and a move into the output register once it is free. A finished result waits in the
// output register while the next word is accepted. The frame RAM is not cleared at reset.
// Depends on msrf_pkg, msrf_ctrl, msrf_dpath and msrf_ram.
`default_nettype none

module minmax_stretch_rotate_frame
    import msrf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_word_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_word_t      result
);

    cmd_t  cmd;
    stat_t stat;

    msrf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_func  (item.func),
        .stat       (stat),
        .cmd        (cmd)
    );

    msrf_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .stat         (stat)
    );

endmodule

`default_nettype wire

/* src/msrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module msrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/msrf_ctrl.sv */
// Controller: input handshake and the readout sequence (fetch, prepare, divide, output).
// Depends on msrf_pkg.
`default_nettype none

module msrf_ctrl
    import msrf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire logic  item_func,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item_func == FUNC_READ)
                    begin
                        cmd.read   = 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register frees up
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_read_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_func == FUNC_READ) |=> (state_reg == S_FETCH))
        else $error("readout word did not start a fetch");

    a_out_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_busy)
        else $error("output register overwritten while full");

    a_full_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && state_next == S_DONE) |-> (step_reg == STEP_W'(DIV_STEPS - 1)))
        else $error("division left before all quotient bits");

endmodule

`default_nettype wire

/* src/msrf_dpath.sv */
// Datapath: byte pairing, rotated address generation, min/max tracking, frame RAM,
// restoring divider and output register. Depends on msrf_pkg and msrf_ram.
`default_nettype none

module msrf_dpath
    import msrf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_t      cmd,
    input  wire in_word_t  item,
    input  wire logic      result_ready,
    output logic           result_valid,
    output out_word_t      result,
    output stat_t          stat
);

    // frame load state
    logic [BYTE_W-1:0]  hold_reg, hold_next;
    logic               phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               closed_reg, closed_next;
    logic [PIX_W-1:0]   min_reg, min_next;
    logic [PIX_W-1:0]   max_reg, max_next;
    logic [ADDR_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;

    // values seen by a load word after an implied frame start
    logic               phase_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [PIX_W-1:0]   min_eff, max_eff;
    logic [COL_W-1:0]   col_eff;
    logic [ROW_W-1:0]   row_eff;
    logic [ADDR_W-1:0]  addr_eff;
    logic [ADDR_W-1:0]  rd_idx_eff;
    logic [PIX_W-1:0]   pixel;
    logic               store;

    // readout
    logic [PIX_W-1:0]   rd_data;
    logic               last_pix_reg;
    logic [GRAY_W-1:0]  fixed_reg;
    logic               use_div_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   dsh_reg;
    logic [GRAY_W-1:0]  quo_reg;
    logic [PIX_W-1:0]   diff;
    logic [PIX_W-1:0]   span;
    logic [GRAY_W-1:0]  fixed_val;
    logic               use_div_val;

    out_word_t          result_reg;
    logic               result_valid_reg, result_valid_next;

    assign phase_eff  = closed_reg ? 1'b0 : phase_reg;
    assign count_eff  = closed_reg ? '0 : count_reg;
    assign min_eff    = closed_reg ? PIX_MAX : min_reg;
    assign max_eff    = closed_reg ? '0 : max_reg;
    assign col_eff    = closed_reg ? '0 : col_reg;
    assign row_eff    = closed_reg ? '0 : row_reg;
    assign addr_eff   = closed_reg ? ADDR_W'(FRAME_ROWS - 1) : wr_addr_reg;
    assign rd_idx_eff = closed_reg ? '0 : rd_idx_reg;
    assign pixel      = {item.raw_byte, hold_reg};
    assign store      = cmd.load && phase_eff && (count_eff < COUNT_W'(PIXELS));

    always_comb
    begin
        hold_next    = hold_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        closed_next  = closed_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        rd_idx_next  = rd_idx_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        wr_addr_next = wr_addr_reg;

        if (cmd.load)
        begin
            phase_next   = ~phase_eff;
            count_next   = count_eff;
            min_next     = min_eff;
            max_next     = max_eff;
            col_next     = col_eff;
            row_next     = row_eff;
            wr_addr_next = addr_eff;
            rd_idx_next  = rd_idx_eff;
            closed_next  = 1'b0;
            if (!phase_eff)
            begin
                hold_next = item.raw_byte;
            end
            if (store)
            begin
                count_next = count_eff + 1'b1;
                if (pixel < min_eff)
                begin
                    min_next = pixel;
                end
                if (pixel > max_eff)
                begin
                    max_next = pixel;
                end
                // walk down the rotated column; wrap to the next source row
                if (col_eff == COL_W'(FRAME_COLS - 1))
                begin
                    col_next     = '0;
                    row_next     = row_eff + 1'b1;
                    wr_addr_next = ADDR_W'(FRAME_ROWS - 2) - ADDR_W'(row_eff);
                end
                else
                begin
                    col_next     = col_eff + 1'b1;
                    wr_addr_next = addr_eff + ADDR_W'(FRAME_ROWS);
                end
            end
            if (item.last_byte)
            begin
                closed_next = 1'b1;
                rd_idx_next = '0;
            end
        end
        else if (cmd.read)
        begin
            rd_idx_next = (rd_idx_reg == ADDR_W'(PIXELS - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= '0;
            phase_reg   <= 1'b0;
            count_reg   <= '0;
            closed_reg  <= 1'b1;
            min_reg     <= PIX_MAX;
            max_reg     <= '0;
            rd_idx_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            wr_addr_reg <= ADDR_W'(FRAME_ROWS - 1);
        end
        else
        begin
            hold_reg    <= hold_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            closed_reg  <= closed_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            rd_idx_reg  <= rd_idx_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            wr_addr_reg <= wr_addr_next;
        end
    end

    msrf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXELS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (addr_eff),
        .wr_data (pixel),
        .rd_en   (cmd.read),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // classify the fetched pixel; only the strictly-inside case needs the divider
    assign diff = rd_data - min_reg;
    assign span = max_reg - min_reg;

    always_comb
    begin
        fixed_val   = '0;
        use_div_val = 1'b0;
        priority if (count_reg == '0 || min_reg > max_reg)
        begin
            fixed_val = '0;
        end
        else if (min_reg == max_reg)
        begin
            fixed_val = rd_data[GRAY_W-1:0];
        end
        else if (rd_data <= min_reg)
        begin
            fixed_val = '0;
        end
        else if (rd_data >= max_reg)
        begin
            fixed_val = GRAY_MAX;
        end
        else
        begin
            use_div_val = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            last_pix_reg <= (rd_idx_reg == ADDR_W'(PIXELS - 1));
        end
        if (cmd.prep)
        begin
            fixed_reg   <= fixed_val;
            use_div_reg <= use_div_val;
            // 255 * diff as (diff << 8) - diff
            rem_reg     <= (NUM_W'(diff) << GRAY_W) - NUM_W'(diff);
            dsh_reg     <= NUM_W'(span) << (DIV_STEPS - 1);
            quo_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[GRAY_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[GRAY_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.out_load)
        begin
            result_reg.gray       <= use_div_reg ? quo_reg : fixed_reg;
            result_reg.last_pixel <= last_pix_reg;
            result_reg.flat_frame <= (min_reg == max_reg);
            result_reg.frame_min  <= min_reg;
            result_reg.frame_max  <= max_reg;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign result        = result_reg;
    assign stat.out_busy = result_valid_reg && !result_ready;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(PIXELS))
        else $error("pixel count ran past the frame size");

    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("frame minimum above maximum with pixels loaded");

    a_store_advances: assert property (@(posedge clk) disable iff (!rst_n)
        store |=> (count_reg == $past(count_eff) + 1'b1))
        else $error("stored pixel not counted");

endmodule

`default_nettype wire
